/* rtl/core/clbc_pkg.sv */
// clbc_pkg: shared types and constants of the character display bus controller
// no dependencies; used by the controller, the datapath and the top level
`default_nettype none

package clbc_pkg;

   // controller to datapath commands
   typedef struct packed {
      logic exec;     // run the accepted item this cycle
      logic respond;  // present the result this cycle
   } dp_cmd_type;

   // command port byte codes
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_HOME         = 8'h02;
   localparam logic [7:0] CMD_ENTRY_MASK   = 8'hFC;
   localparam logic [7:0] CMD_ENTRY_CODE   = 8'h04;
   localparam logic [7:0] CMD_DISP_MASK    = 8'hF8;
   localparam logic [7:0] CMD_DISP_CODE    = 8'h08;
   localparam logic [7:0] CMD_COUNT_UP_BIT = 8'h02;
   localparam logic [7:0] CMD_DISP_ON_BIT  = 8'h04;
   localparam logic [7:0] CMD_CURSOR_BIT   = 8'h02;
   localparam logic [7:0] CMD_CHAR_ADDR    = 8'h80;
   localparam logic [7:0] CMD_GLYPH_ADDR   = 8'h40;
   localparam logic [7:0] CHAR_ADDR_MASK   = 8'h7F;
   localparam logic [7:0] GLYPH_ADDR_MASK  = 8'h3F;

   localparam logic [7:0] SPACE_CHAR       = 8'h20;
   localparam logic [7:0] GLYPH_BLANK      = 8'h00;

   localparam logic       MODE_READ        = 1'b0;
   localparam logic       MODE_WRITE       = 1'b1;

   localparam logic       STATUS_OK        = 1'b0;
   localparam logic       STATUS_INVALID   = 1'b1;

   localparam logic [15:0] BASE_RESET      = 16'd192;

endpackage

`default_nettype wire

/* rtl/core/char_lcd_bus_controller_unit.sv */
// char_lcd_bus_controller_unit: top level of the character display bus controller
// depends on clbc_pkg, clbc_ctrl, clbc_datapath and clbc_ram
//
// usage:
//   request channel: drive req_mode, req_bus_address and req_write_data with
//   start high; the item is taken at the rising edge where start is high and
//   busy is low. busy is high while the result of an accepted item is presented.
//   result channel: rsp_valid is high for exactly one cycle, the cycle after
//   acceptance, with rsp_read_data, rsp_status, rsp_display_enabled and
//   rsp_cursor_enabled valid in that cycle. the receiver cannot stall it.
//   a new item is not taken while the result of the last one is presented.
//   the clear command does not walk the character memory: its per-entry
//   valid flags are dropped at once and unwritten character entries read
//   as spaces.
//   configuration: csr_write_enable with csr_write_data sets the command port
//   address; write it only while no item is in flight.
//   reset (synchronous, active high) sets the port address to 192, all
//   character bytes to spaces, all glyph bytes to zero, display on, cursor off.
`default_nettype none

module char_lcd_bus_controller_unit #(
   parameter int CHAR_DEPTH  = 80,
   parameter int GLYPH_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_mode,
   input  wire logic [15:0] req_bus_address,
   input  wire logic [7:0]  req_write_data,
   output logic             rsp_valid,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_status,
   output logic             rsp_display_enabled,
   output logic             rsp_cursor_enabled,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);
   import clbc_pkg::*;

   dp_cmd_type cmd;

   clbc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   clbc_datapath #(
      .CHAR_DEPTH  (CHAR_DEPTH),
      .GLYPH_DEPTH (GLYPH_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_mode            (req_mode),
      .req_bus_address     (req_bus_address),
      .req_write_data      (req_write_data),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_read_data       (rsp_read_data),
      .rsp_status          (rsp_status),
      .rsp_display_enabled (rsp_display_enabled),
      .rsp_cursor_enabled  (rsp_cursor_enabled)
   );

   assign rsp_valid = cmd.respond;

endmodule

`default_nettype wire

/* rtl/core/clbc_ram.sv */
// clbc_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none

module clbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/core/clbc_ctrl.sv */
// clbc_ctrl: item sequencer, an execute step then a result step
// depends on clbc_pkg
`default_nettype none

module clbc_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   output clbc_pkg::dp_cmd_type cmd
);
   import clbc_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RESP = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.exec    = 1'b0;
      cmd.respond = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.exec = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == ST_RESP);

endmodule

`default_nettype wire

/* rtl/core/clbc_datapath.sv */
// clbc_datapath: address decode, command execution, counter, flags and memories
// depends on clbc_pkg and clbc_ram
`default_nettype none

module clbc_datapath #(
   parameter int CHAR_DEPTH  = 80,
   parameter int GLYPH_DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire clbc_pkg::dp_cmd_type cmd,
   input  wire logic                 req_mode,
   input  wire logic [15:0]          req_bus_address,
   input  wire logic [7:0]           req_write_data,
   input  wire logic                 csr_write_enable,
   input  wire logic [15:0]          csr_write_data,
   output logic [7:0]                rsp_read_data,
   output logic                      rsp_status,
   output logic                      rsp_display_enabled,
   output logic                      rsp_cursor_enabled
);
   import clbc_pkg::*;

   localparam int CAW = $clog2(CHAR_DEPTH);
   localparam int GAW = $clog2(GLYPH_DEPTH);

   localparam logic [1:0] RD_ZERO    = 2'd0;
   localparam logic [1:0] RD_COUNTER = 2'd1;
   localparam logic [1:0] RD_CHAR    = 2'd2;
   localparam logic [1:0] RD_GLYPH   = 2'd3;

   // counter mod depth by repeated subtract; the user keeps depth at least 32 (unchecked here), so four steps cover 127
   function automatic logic [CAW-1:0] char_index(input logic [6:0] cnt);
      logic [7:0] v;
      v = {1'b0, cnt};
      for (int i = 0; i < 4; i++) begin
         if (v >= 8'(CHAR_DEPTH)) begin
            v = v - 8'(CHAR_DEPTH);
         end
      end
      return v[CAW-1:0];
   endfunction

   logic [15:0]            base_ff;
   logic [6:0]             counter_ff,   counter_in;
   logic                   glyph_sel_ff, glyph_sel_in;
   logic                   count_up_ff,  count_up_in;
   logic                   disp_ff,      disp_in;
   logic                   cursor_ff,    cursor_in;
   logic [CHAR_DEPTH-1:0]  char_valid_ff,  char_valid_in;
   logic [GLYPH_DEPTH-1:0] glyph_valid_ff, glyph_valid_in;
   logic [1:0]             rsel_ff,   rsel_in;
   logic                   rvalid_ff, rvalid_in;
   logic                   status_ff, status_in;

   logic                   cmd_hit;
   logic                   data_hit;
   logic [CAW-1:0]         cidx;
   logic [GAW-1:0]         gidx;
   logic                   char_we;
   logic                   glyph_we;
   logic [7:0]             char_q;
   logic [7:0]             glyph_q;

   assign cmd_hit  = (req_bus_address == base_ff);
   // base plus one is formed in 17 bits so a base at the top never matches
   assign data_hit = ({1'b0, req_bus_address} == ({1'b0, base_ff} + 17'd1));
   assign cidx     = char_index(counter_ff);
   assign gidx     = counter_ff[GAW-1:0];

   always_comb begin
      counter_in     = counter_ff;
      glyph_sel_in   = glyph_sel_ff;
      count_up_in    = count_up_ff;
      disp_in        = disp_ff;
      cursor_in      = cursor_ff;
      char_valid_in  = char_valid_ff;
      glyph_valid_in = glyph_valid_ff;
      rsel_in        = rsel_ff;
      rvalid_in      = rvalid_ff;
      status_in      = status_ff;
      char_we        = 1'b0;
      glyph_we       = 1'b0;

      if (cmd.exec) begin
         rsel_in   = RD_ZERO;
         rvalid_in = 1'b0;
         status_in = STATUS_OK;
         if (cmd_hit) begin
            if (req_mode == MODE_WRITE) begin
               if (req_write_data == CMD_CLEAR) begin
                  char_valid_in = '0;
                  counter_in    = '0;
                  glyph_sel_in  = 1'b0;
               end else if (req_write_data == CMD_HOME) begin
                  counter_in   = '0;
                  glyph_sel_in = 1'b0;
               end else if ((req_write_data & CMD_ENTRY_MASK) == CMD_ENTRY_CODE) begin
                  count_up_in = |(req_write_data & CMD_COUNT_UP_BIT);
               end else if ((req_write_data & CMD_DISP_MASK) == CMD_DISP_CODE) begin
                  disp_in   = |(req_write_data & CMD_DISP_ON_BIT);
                  cursor_in = |(req_write_data & CMD_CURSOR_BIT);
               end else if (|(req_write_data & CMD_CHAR_ADDR)) begin
                  counter_in   = 7'(req_write_data & CHAR_ADDR_MASK);
                  glyph_sel_in = 1'b0;
               end else if (|(req_write_data & CMD_GLYPH_ADDR)) begin
                  counter_in   = 7'(req_write_data & GLYPH_ADDR_MASK);
                  glyph_sel_in = 1'b1;
               end
            end else begin
               rsel_in = RD_COUNTER;
            end
         end else if (data_hit) begin
            if (req_mode == MODE_WRITE) begin
               if (glyph_sel_ff) begin
                  glyph_we             = 1'b1;
                  glyph_valid_in[gidx] = 1'b1;
               end else begin
                  char_we             = 1'b1;
                  char_valid_in[cidx] = 1'b1;
               end
            end else begin
               rsel_in   = glyph_sel_ff ? RD_GLYPH : RD_CHAR;
               rvalid_in = glyph_sel_ff ? glyph_valid_ff[gidx] : char_valid_ff[cidx];
            end
            counter_in = count_up_ff ? counter_ff + 7'd1 : counter_ff - 7'd1;
         end else begin
            status_in = STATUS_INVALID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff        <= BASE_RESET;
         counter_ff     <= '0;
         glyph_sel_ff   <= 1'b0;
         count_up_ff    <= 1'b1;
         disp_ff        <= 1'b1;
         cursor_ff      <= 1'b0;
         char_valid_ff  <= '0;
         glyph_valid_ff <= '0;
         rsel_ff        <= RD_ZERO;
         rvalid_ff      <= 1'b0;
         status_ff      <= STATUS_OK;
      end else begin
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
         counter_ff     <= counter_in;
         glyph_sel_ff   <= glyph_sel_in;
         count_up_ff    <= count_up_in;
         disp_ff        <= disp_in;
         cursor_ff      <= cursor_in;
         char_valid_ff  <= char_valid_in;
         glyph_valid_ff <= glyph_valid_in;
         rsel_ff        <= rsel_in;
         rvalid_ff      <= rvalid_in;
         status_ff      <= status_in;
      end
   end

   clbc_ram #(.WIDTH(8), .DEPTH(CHAR_DEPTH)) u_char_ram (
      .clock (clock),
      .we    (char_we),
      .addr  (cidx),
      .wdata (req_write_data),
      .rdata (char_q)
   );

   clbc_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_glyph_ram (
      .clock (clock),
      .we    (glyph_we),
      .addr  (gidx),
      .wdata (req_write_data),
      .rdata (glyph_q)
   );

   // entries never written since reset, or char entries since clear, read as their reset value
   always_comb begin
      case (rsel_ff)
         RD_COUNTER: rsp_read_data = {1'b0, counter_ff};
         RD_CHAR:    rsp_read_data = rvalid_ff ? char_q : SPACE_CHAR;
         RD_GLYPH:   rsp_read_data = rvalid_ff ? glyph_q : GLYPH_BLANK;
         default:    rsp_read_data = '0;
      endcase
      if (!cmd.respond) begin
         rsp_read_data = '0;
      end
   end

   assign rsp_status          = cmd.respond & status_ff;
   assign rsp_display_enabled = disp_ff;
   assign rsp_cursor_enabled  = cursor_ff;

endmodule

`default_nettype wire

/* tb/tb_char_lcd_bus_controller_unit.sv */
// tb_char_lcd_bus_controller_unit: self-checking bench for the character display bus controller
// drives bus accesses through a queue-fed driver, predicts each result and checks it in a monitor
// depends on clbc_pkg and char_lcd_bus_controller_unit
`default_nettype none

module tb_char_lcd_bus_controller_unit;
   import clbc_pkg::*;

   localparam int CHAR_DEPTH  = 80;
   localparam int GLYPH_DEPTH = 64;

   typedef struct {
      logic        mode;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
      int          gap;
      bit          drain;
   } bus_access_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       status;
      logic       display_enabled;
      logic       cursor_enabled;
   } lcd_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = MODE_READ;
   logic [15:0] req_bus_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_data;
   logic        rsp_status;
   logic        rsp_display_enabled;
   logic        rsp_cursor_enabled;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   char_lcd_bus_controller_unit #(
      .CHAR_DEPTH (CHAR_DEPTH),
      .GLYPH_DEPTH(GLYPH_DEPTH)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_bus_address    (req_bus_address),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_read_data      (rsp_read_data),
      .rsp_status         (rsp_status),
      .rsp_display_enabled(rsp_display_enabled),
      .rsp_cursor_enabled (rsp_cursor_enabled),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the controller state
   logic [15:0] port_base = BASE_RESET;
   logic [7:0]  char_mem [CHAR_DEPTH];
   logic [7:0]  glyph_mem [GLYPH_DEPTH];
   logic [6:0]  addr_count = '0;
   logic        glyph_sel = 1'b0;
   logic        count_up = 1'b1;
   logic        disp_shadow = 1'b1;
   logic        cursor_shadow = 1'b0;

   bus_access_type pending_accesses[$];
   lcd_result_type expected_results[$];
   int          items_issued = 0;
   int          results_seen = 0;
   int          error_count = 0;
   bit          burst_mode = 1'b0;

   initial begin
      for (int i = 0; i < CHAR_DEPTH; i++) char_mem[i] = SPACE_CHAR;
      for (int i = 0; i < GLYPH_DEPTH; i++) glyph_mem[i] = GLYPH_BLANK;
   end

   function automatic void apply_command(logic [7:0] cmd);
      if (cmd == CMD_CLEAR) begin
         for (int i = 0; i < CHAR_DEPTH; i++) char_mem[i] = SPACE_CHAR;
         addr_count = '0;
         glyph_sel = 1'b0;
      end else if (cmd == CMD_HOME) begin
         addr_count = '0;
         glyph_sel = 1'b0;
      end else if ((cmd & CMD_ENTRY_MASK) == CMD_ENTRY_CODE) begin
         count_up = |(cmd & CMD_COUNT_UP_BIT);
      end else if ((cmd & CMD_DISP_MASK) == CMD_DISP_CODE) begin
         disp_shadow = |(cmd & CMD_DISP_ON_BIT);
         cursor_shadow = |(cmd & CMD_CURSOR_BIT);
      end else if (|(cmd & CMD_CHAR_ADDR)) begin
         addr_count = 7'(cmd & CHAR_ADDR_MASK);
         glyph_sel = 1'b0;
      end else if (|(cmd & CMD_GLYPH_ADDR)) begin
         addr_count = 7'(cmd & GLYPH_ADDR_MASK);
         glyph_sel = 1'b1;
      end
   endfunction

   function automatic lcd_result_type predict_access(logic mode, logic [15:0] addr,
                                                     logic [7:0] data);
      lcd_result_type res;
      int unsigned a;
      int unsigned b;
      int          idx;
      a = addr;
      b = port_base;
      res.read_data = '0;
      res.status = STATUS_OK;
      if (a < b || a - b > 1) begin
         res.status = STATUS_INVALID;
      end else if (a == b) begin
         if (mode == MODE_WRITE) apply_command(data);
         else res.read_data = {1'b0, addr_count};
      end else begin
         if (glyph_sel) begin
            idx = addr_count % GLYPH_DEPTH;
            if (mode == MODE_WRITE) glyph_mem[idx] = data;
            else res.read_data = glyph_mem[idx];
         end else begin
            idx = addr_count % CHAR_DEPTH;
            if (mode == MODE_WRITE) char_mem[idx] = data;
            else res.read_data = char_mem[idx];
         end
         addr_count = count_up ? addr_count + 7'd1 : addr_count - 7'd1;
      end
      res.display_enabled = disp_shadow;
      res.cursor_enabled = cursor_shadow;
      return res;
   endfunction

   // driver: presents queued items, holds them while busy, idles for each item's gap
   int gap_left = 0;

   always @(posedge clock) begin
      bus_access_type nxt;
      logic        fire;
      logic        nxt_start;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            expected_results.push_back(predict_access(req_mode, req_bus_address,
                                                      req_write_data));
            items_issued++;
         end
         if (!(start && !fire)) begin
            nxt_start = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_accesses.size() != 0 &&
                         (!pending_accesses[0].drain || items_issued == results_seen)) begin
               nxt = pending_accesses.pop_front();
               req_mode <= nxt.mode;
               req_bus_address <= nxt.bus_address;
               req_write_data <= nxt.write_data;
               gap_left = nxt.gap;
               nxt_start = 1'b1;
            end
            start <= nxt_start;
         end
      end
   end

   function automatic void check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s expected %0h got %0h", name, exp_val, act_val);
         error_count++;
      end
   endfunction

   // monitor: every strobe is matched against the oldest prediction
   always @(posedge clock) begin
      lcd_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result with no item outstanding");
            error_count++;
         end else begin
            exp_res = expected_results.pop_front();
            check_field("read_data", exp_res.read_data, rsp_read_data);
            check_field("status", exp_res.status, rsp_status);
            check_field("display_enabled", exp_res.display_enabled, rsp_display_enabled);
            check_field("cursor_enabled", exp_res.cursor_enabled, rsp_cursor_enabled);
         end
         results_seen <= results_seen + 1;
      end
   end

   // mostly short gaps, a few long ones, with stretches of back-to-back items
   function automatic int pick_gap();
      int sel;
      if (burst_mode) return 0;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic queue_access(logic mode, logic [15:0] addr, logic [7:0] data);
      bus_access_type item;
      item.mode = mode;
      item.bus_address = addr;
      item.write_data = data;
      item.gap = pick_gap();
      item.drain = ($urandom_range(0, 99) < 2);
      pending_accesses.push_back(item);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_accesses.size() != 0 || start || items_issued != results_seen)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic program_base(logic [15:0] value);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      port_base = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_command();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 3) return CMD_CLEAR;
      if (sel < 10) return CMD_HOME;
      if (sel < 22) return CMD_ENTRY_CODE | 8'($urandom_range(0, 3));
      if (sel < 40) return CMD_DISP_CODE | 8'($urandom_range(0, 7));
      if (sel < 60) return CMD_CHAR_ADDR | 8'($urandom_range(0, 127));
      if (sel < 78) return CMD_GLYPH_ADDR | 8'($urandom_range(0, 63));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_random(int count);
      int          sel;
      logic        mode;
      logic [15:0] addr;
      logic [7:0]  data;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
         sel = $urandom_range(0, 99);
         data = 8'($urandom_range(0, 255));
         mode = 1'($urandom_range(0, 1));
         if (sel < 35) begin
            addr = port_base;
            if ($urandom_range(0, 9) < 7) begin
               mode = MODE_WRITE;
               data = random_command();
            end
         end else if (sel < 70) begin
            addr = port_base + 16'd1;
         end else if (sel < 80) begin
            addr = ($urandom_range(0, 1) != 0) ? port_base - 16'd1 : port_base + 16'd2;
         end else begin
            addr = 16'($urandom_range(0, 65535));
         end
         queue_access(mode, addr, data);
      end
   endtask

   task automatic queue_directed();
      logic [15:0] cmd_port;
      logic [15:0] data_port;
      cmd_port = port_base;
      data_port = port_base + 16'd1;
      queue_access(MODE_READ, cmd_port, 8'hFF);
      queue_access(MODE_READ, data_port, 8'h00);
      // unlisted command bytes do nothing
      queue_access(MODE_WRITE, cmd_port, 8'h00);
      queue_access(MODE_WRITE, cmd_port, 8'h03);
      queue_access(MODE_WRITE, cmd_port, CMD_DISP_CODE | CMD_CURSOR_BIT);
      queue_access(MODE_WRITE, cmd_port, CMD_DISP_CODE | 8'h07);
      // counter at 127 selects character index 127 mod depth, then wraps to 0
      queue_access(MODE_WRITE, cmd_port, CMD_CHAR_ADDR | CHAR_ADDR_MASK);
      queue_access(MODE_WRITE, data_port, 8'hFF);
      queue_access(MODE_READ, cmd_port, 8'h00);
      queue_access(MODE_WRITE, cmd_port, CMD_CHAR_ADDR | 8'h2F);
      queue_access(MODE_READ, data_port, 8'h00);
      // count down and wrap below zero
      queue_access(MODE_WRITE, cmd_port, CMD_ENTRY_CODE);
      queue_access(MODE_WRITE, cmd_port, CMD_CHAR_ADDR);
      queue_access(MODE_READ, data_port, 8'h00);
      queue_access(MODE_READ, cmd_port, 8'h00);
      queue_access(MODE_WRITE, cmd_port, CMD_GLYPH_ADDR | GLYPH_ADDR_MASK);
      queue_access(MODE_WRITE, data_port, 8'hAA);
      queue_access(MODE_WRITE, cmd_port, CMD_ENTRY_CODE | 8'h03);
      queue_access(MODE_WRITE, cmd_port, CMD_GLYPH_ADDR | GLYPH_ADDR_MASK);
      queue_access(MODE_READ, data_port, 8'h00);
      queue_access(MODE_WRITE, cmd_port, CMD_HOME);
      queue_access(MODE_WRITE, cmd_port, CMD_CLEAR);
      // both address bits set: character address wins
      queue_access(MODE_WRITE, cmd_port, CMD_CHAR_ADDR | CMD_GLYPH_ADDR | 8'h2F);
      queue_access(MODE_READ, data_port, 8'h00);
      queue_access(MODE_READ, 16'h0000, 8'h00);
      queue_access(MODE_WRITE, 16'hFFFF, 8'h55);
      queue_access(MODE_READ, cmd_port - 16'd1, 8'h00);
      queue_access(MODE_WRITE, cmd_port + 16'd2, 8'h01);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_directed();
      queue_random(200);
      program_base(16'h0000);
      queue_random(250);
      program_base(16'hFFFE);
      queue_random(250);
      // data port would be past the top of the bus here
      program_base(16'hFFFF);
      queue_random(120);
      program_base(16'($urandom_range(0, 65534)));
      queue_random(300);
      program_base(BASE_RESET);
      queue_random(450);
      wait_idle();
      repeat (4) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
